[rtl/mcr_pkg.sv]
`timescale 1ns / 1ps

package mcr_pkg;

  // Coordinate, decision and pixel widths
  localparam int COORD_BITS = 16;
  localparam int DEC_BITS   = 24;
  localparam int PIX_BITS   = 17;
  localparam int COLOR_BITS = 8;
  localparam int FIX_BITS   = 32;
  localparam int FRAC_BITS  = 16;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Pixel index of the first pixel of each group and of the last pixel
  localparam logic [2:0] IDX_FULL = 3'd0;
  localparam logic [2:0] IDX_SWAP = 3'd4;
  localparam logic [2:0] IDX_LAST = 3'd7;

  // One step's worth of pixels, handed from the core to the emitter
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] ox;
    logic signed [COORD_BITS-1:0] oy;
    logic [COLOR_BITS-1:0]        color;
    logic                         swap_only;
    logic                         fin;
  } mcr_job_t;

  // Integer part of a 16.16 value, wrapped to the coordinate width
  function automatic logic signed [COORD_BITS-1:0] fix_int(input logic [FIX_BITS-1:0] raw);
    fix_int = raw[FRAC_BITS +: COORD_BITS];
  endfunction

  // Sign-extend a coordinate to the decision width
  function automatic logic signed [DEC_BITS-1:0] ext_dec(input logic [COORD_BITS-1:0] v);
    ext_dec = {{(DEC_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  // Sign-extend a coordinate to the pixel width
  function automatic logic signed [PIX_BITS-1:0] ext_pix(input logic [COORD_BITS-1:0] v);
    ext_pix = {{(PIX_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

endpackage

[rtl/mcr_core.sv]
`timescale 1ns / 1ps

module mcr_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic                                  command_i,
  input  logic signed [mcr_pkg::FIX_BITS-1:0]   center_x_fix_i,
  input  logic signed [mcr_pkg::FIX_BITS-1:0]   center_y_fix_i,
  input  logic signed [mcr_pkg::FIX_BITS-1:0]   radius_fix_i,
  input  logic [mcr_pkg::COLOR_BITS-1:0]        pen_color_i,
  output logic                                  job_valid_o,
  output mcr_pkg::mcr_job_t                     job_o
);

  logic signed [mcr_pkg::COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [mcr_pkg::COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic signed [mcr_pkg::DEC_BITS-1:0]   dec_q, dec_d;
  logic [mcr_pkg::COLOR_BITS-1:0]        color_q, color_d;
  logic                                  active_q, active_d;

  logic signed [mcr_pkg::COORD_BITS-1:0] r;
  logic signed [mcr_pkg::COORD_BITS-1:0] x_nx, y_nx;
  logic signed [mcr_pkg::DEC_BITS-1:0]   x_ext, y_ext;

  assign r     = mcr_pkg::fix_int(radius_fix_i);
  assign x_ext = mcr_pkg::ext_dec(x_q);
  assign y_ext = mcr_pkg::ext_dec(y_q);
  assign x_nx  = x_q + mcr_pkg::COORD_BITS'(1);
  assign y_nx  = dec_q[mcr_pkg::DEC_BITS-1] ? y_q : y_q - mcr_pkg::COORD_BITS'(1);

  // Decode the request and advance the circle state
  always_comb begin
    cx_d        = cx_q;
    cy_d        = cy_q;
    x_d         = x_q;
    y_d         = y_q;
    dec_d       = dec_q;
    color_d     = color_q;
    active_d    = active_q;
    job_valid_o = 1'b0;
    job_o.cx        = cx_q;
    job_o.cy        = cy_q;
    job_o.ox        = x_q;
    job_o.oy        = y_q;
    job_o.color     = color_q;
    job_o.swap_only = 1'b0;
    job_o.fin       = 1'b0;
    if (accept_i) begin
      if (command_i == mcr_pkg::CMD_START) begin
        cx_d     = mcr_pkg::fix_int(center_x_fix_i);
        cy_d     = mcr_pkg::fix_int(center_y_fix_i);
        color_d  = pen_color_i;
        x_d      = '0;
        y_d      = r;
        dec_d    = mcr_pkg::DEC_BITS'(3) - (mcr_pkg::ext_dec(r) <<< 1);
        active_d = !r[mcr_pkg::COORD_BITS-1];
      end else if (active_q) begin
        if (x_q < y_q) begin
          job_valid_o = 1'b1;
          if (dec_q[mcr_pkg::DEC_BITS-1]) begin
            dec_d = dec_q + (x_ext <<< 2) + mcr_pkg::DEC_BITS'(6);
          end else begin
            dec_d = dec_q + ((x_ext - y_ext) <<< 2) + mcr_pkg::DEC_BITS'(10);
          end
          x_d = x_nx;
          y_d = y_nx;
          if (x_nx > y_nx) begin
            job_o.fin = 1'b1;
            active_d  = 1'b0;
          end
        end else if (x_q == y_q) begin
          job_valid_o     = 1'b1;
          job_o.swap_only = 1'b1;
          job_o.fin       = 1'b1;
          active_d        = 1'b0;
        end else begin
          active_d = 1'b0;
        end
      end
    end
  end

  // Hold the circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      dec_q    <= dec_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

endmodule

[rtl/mcr_emit.sv]
`timescale 1ns / 1ps

module mcr_emit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  mcr_pkg::mcr_job_t                     job_i,
  output logic                                  free_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mcr_pkg::PIX_BITS-1:0]   pixel_x_o,
  output logic signed [mcr_pkg::PIX_BITS-1:0]   pixel_y_o,
  output logic [mcr_pkg::COLOR_BITS-1:0]        pixel_color_o,
  output logic                                  finished_o
);

  logic              valid_q, valid_d;
  logic [2:0]        idx_q, idx_d;
  mcr_pkg::mcr_job_t job_q, job_d;

  logic                                 last;
  logic signed [mcr_pkg::PIX_BITS-1:0]  cx_e, cy_e, dx_e, dy_e;

  assign last   = (idx_q == mcr_pkg::IDX_LAST);
  assign free_o = !valid_q || (out_ready_i && last);

  // Select the offsets for the current pixel: lower half swaps x and y
  assign cx_e = mcr_pkg::ext_pix(job_q.cx);
  assign cy_e = mcr_pkg::ext_pix(job_q.cy);
  assign dx_e = mcr_pkg::ext_pix(idx_q[2] ? job_q.ox : job_q.oy);
  assign dy_e = mcr_pkg::ext_pix(idx_q[2] ? job_q.oy : job_q.ox);

  assign out_valid_o   = valid_q;
  assign pixel_x_o     = idx_q[0] ? cx_e + dx_e : cx_e - dx_e;
  assign pixel_y_o     = idx_q[1] ? cy_e + dy_e : cy_e - dy_e;
  assign pixel_color_o = job_q.color;
  assign finished_o    = job_q.fin && last;

  // Advance through the pixels of the step, load the next step when free
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    job_d   = job_q;
    if (valid_q && out_ready_i) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      job_d   = job_i;
      idx_d   = job_i.swap_only ? mcr_pkg::IDX_SWAP : mcr_pkg::IDX_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= mcr_pkg::IDX_FULL;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Hold the step payload
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

[rtl/midpoint_circle_rasterizer.sv]
`timescale 1ns / 1ps

// Midpoint circle rasterizer.
// Input channel (in_valid_i / in_ready_o) takes one request per handshake:
// command 0 starts a circle from a 16.16 center and radius and a pen color
// and produces no pixel; command 1 advances the circle by one step.
// Output channel (out_valid_o / out_ready_i) delivers one pixel per
// handshake with its color; finished_o marks the last pixel of the circle.
// A step produces eight pixels, or four on the closing step where x meets
// y, or none when no circle is in progress. The first pixel of a step is
// valid the cycle after the step is accepted, and the pixels follow one per
// cycle while the receiver takes them.
// The next request is accepted in the cycle the last pixel of the current
// step is taken, so steps run back to back with no gap.
// When the receiver stalls the current pixel holds and in_ready_o drops
// once a step is waiting on it. Reset clears the circle state and any
// pixels in flight; no circle is active afterwards.
module midpoint_circle_rasterizer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  command_i,
  input  logic signed [mcr_pkg::FIX_BITS-1:0]   center_x_fix_i,
  input  logic signed [mcr_pkg::FIX_BITS-1:0]   center_y_fix_i,
  input  logic signed [mcr_pkg::FIX_BITS-1:0]   radius_fix_i,
  input  logic [mcr_pkg::COLOR_BITS-1:0]        pen_color_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mcr_pkg::PIX_BITS-1:0]   pixel_x_o,
  output logic signed [mcr_pkg::PIX_BITS-1:0]   pixel_y_o,
  output logic [mcr_pkg::COLOR_BITS-1:0]        pixel_color_o,
  output logic                                  finished_o
);

  logic              accept;
  logic              job_valid;
  logic              free;
  mcr_pkg::mcr_job_t job;

  // Take a request only when the sequencer can load its pixels
  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  mcr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .center_x_fix_i (center_x_fix_i),
    .center_y_fix_i (center_y_fix_i),
    .radius_fix_i   (radius_fix_i),
    .pen_color_i    (pen_color_i),
    .job_valid_o    (job_valid),
    .job_o          (job)
  );

  mcr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (job_valid),
    .job_i         (job),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .finished_o    (finished_o)
  );

endmodule
